[hw/rtl/c_keyword_counter_macros.svh]
// ----------------------------------------------------------------------------
// c_keyword_counter_macros.svh
// Assertion macros shared by the keyword counter modules.
// ----------------------------------------------------------------------------
`ifndef C_KEYWORD_COUNTER_MACROS_SVH
`define C_KEYWORD_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define CKC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c_keyword_counter: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CKC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c_keyword_counter: assertion failed");

`else

`define CKC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CKC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/ckc_pkg.sv]
// ----------------------------------------------------------------------------
// ckc_pkg
// Types, constants and keyword table of the C keyword counter.
// ----------------------------------------------------------------------------
package ckc_pkg;

    localparam int MAX_KEY_LEN_DEF  = 8;
    localparam int NUM_KEYWORDS_DEF = 12;
    localparam int EVENT_DEPTH_DEF  = 4;
    localparam int COUNT_BITS       = 16;
    localparam int TABLE_SIZE       = 12;
    localparam int KW_TEXT_LEN      = 8;
    localparam int KW_SEL_BITS      = 4;
    localparam int KEY_INDEX_BITS   = 4;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_item_t;

    typedef struct packed {
        logic [KEY_INDEX_BITS-1:0] keyword_index;
        logic [COUNT_BITS-1:0]     keyword_count;
        logic                      final_entry;
    } count_item_t;

    // One closed word or end of text, as handed from the lexer to the counters
    typedef struct packed {
        logic                   hit;
        logic [KW_SEL_BITS-1:0] sel;
        logic                   dump;
    } kw_event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_word_byte(input logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDERLINE);
    endfunction

    function automatic int kw_len(input int k);
        int n;
        unique case (k)
            0:       n = 4;
            1:       n = 5;
            2:       n = 4;
            3:       n = 4;
            4:       n = 5;
            5:       n = 8;
            6:       n = 7;
            7:       n = 6;
            8:       n = 8;
            9:       n = 4;
            10:      n = 8;
            11:      n = 5;
            default: n = 0;
        endcase
        return n;
    endfunction

    // Right-justified text; first character in the highest used byte
    function automatic logic [8*KW_TEXT_LEN-1:0] kw_str(input int k);
        logic [8*KW_TEXT_LEN-1:0] s;
        unique case (k)
            0:       s = "auto";
            1:       s = "break";
            2:       s = "case";
            3:       s = "char";
            4:       s = "const";
            5:       s = "continue";
            6:       s = "default";
            7:       s = "printf";
            8:       s = "unsigned";
            9:       s = "void";
            10:      s = "volatile";
            11:      s = "while";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] kw_char(input int k, input int j);
        logic [8*KW_TEXT_LEN-1:0] s;
        s = kw_str(k) << (8 * (KW_TEXT_LEN - kw_len(k)));
        return s[8*(KW_TEXT_LEN-1-j) +: 8];
    endfunction

endpackage

[hw/rtl/ckc_front.sv]
// ----------------------------------------------------------------------------
// ckc_front
// Lexer: scans one byte per transfer, tracks comments, strings, directives
// and words, and matches each closed word against the keyword table.
// ----------------------------------------------------------------------------
`include "c_keyword_counter_macros.svh"

module ckc_front
    import ckc_pkg::*;
#(
    parameter int MAX_KEY_LEN  = MAX_KEY_LEN_DEF,
    parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  text_item_t text_item,
    output logic       ev_write,
    output kw_event_t  ev
);

    localparam int IDX_W  = $clog2(MAX_KEY_LEN);
    localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);
    localparam int ACTIVE = (NUM_KEYWORDS < TABLE_SIZE) ? NUM_KEYWORDS : TABLE_SIZE;

    localparam logic [3:0] M_NORMAL        = 4'd0;
    localparam logic [3:0] M_SLASH         = 4'd1;
    localparam logic [3:0] M_COMMENT       = 4'd2;
    localparam logic [3:0] M_COMMENT_STAR  = 4'd3;
    localparam logic [3:0] M_STRING        = 4'd4;
    localparam logic [3:0] M_STRING_ESC    = 4'd5;
    localparam logic [3:0] M_DIRECTIVE     = 4'd6;
    localparam logic [3:0] M_DIRECTIVE_ESC = 4'd7;
    localparam logic [3:0] M_BACKSLASH     = 4'd8;
    localparam logic [3:0] M_WORD          = 4'd9;

    logic [3:0]       mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovl_reg, ovl_next;
    logic             letter_reg, letter_next;
    logic [7:0]       chars_reg  [MAX_KEY_LEN];
    logic [7:0]       chars_next [MAX_KEY_LEN];

    logic [7:0]       b;
    logic             last;
    logic             b_word;
    logic [3:0]       tok_mode;
    logic             tok_start;
    logic             start;
    logic             append;
    logic             close_cur;
    logic             close_end;

    logic [7:0]       w_chars [MAX_KEY_LEN];
    logic [LEN_W-1:0] w_len;
    logic             w_ok;
    logic             found;
    logic [KW_SEL_BITS-1:0] found_sel;

    assign b      = text_item.text_byte;
    assign last   = text_item.end_of_text;
    assign b_word = is_word_byte(b);

    // Where a fresh token would go for this byte
    always_comb
    begin
        tok_start = 1'b0;
        priority if (b == CH_SLASH)
            tok_mode = M_SLASH;
        else if (b == CH_QUOTE)
            tok_mode = M_STRING;
        else if (b == CH_HASH)
            tok_mode = M_DIRECTIVE;
        else if (b == CH_BACKSLASH)
            tok_mode = M_BACKSLASH;
        else if (b_word)
        begin
            tok_mode  = M_WORD;
            tok_start = 1'b1;
        end
        else
            tok_mode = M_NORMAL;
    end

    always_comb
    begin
        mode_next = mode_reg;
        start     = 1'b0;
        append    = 1'b0;
        close_cur = 1'b0;
        unique case (mode_reg)
            M_SLASH:
            begin
                if (b == CH_STAR)
                    mode_next = M_COMMENT;
                else
                begin
                    mode_next = tok_mode;
                    start     = tok_start;
                end
            end
            M_COMMENT:
            begin
                if (b == CH_STAR)
                    mode_next = M_COMMENT_STAR;
            end
            M_COMMENT_STAR:
            begin
                if (b == CH_SLASH)
                    mode_next = M_NORMAL;
                else if (b != CH_STAR)
                    mode_next = M_COMMENT;
            end
            M_STRING:
            begin
                if (b == CH_BACKSLASH)
                    mode_next = M_STRING_ESC;
                else if (b == CH_QUOTE)
                    mode_next = M_NORMAL;
            end
            M_STRING_ESC:
                mode_next = M_STRING;
            M_DIRECTIVE:
            begin
                if (b == CH_BACKSLASH)
                    mode_next = M_DIRECTIVE_ESC;
                else if (b == CH_NEWLINE)
                    mode_next = M_NORMAL;
            end
            M_DIRECTIVE_ESC:
                mode_next = M_DIRECTIVE;
            M_BACKSLASH:
            begin
                mode_next = b_word ? M_WORD : M_NORMAL;
                start     = b_word;
            end
            M_WORD:
            begin
                if (b_word)
                    append = 1'b1;
                else
                begin
                    close_cur = 1'b1;
                    mode_next = tok_mode;
                end
            end
            default:
            begin
                mode_next = tok_mode;
                start     = tok_start;
            end
        endcase
    end

    // Word buffer update
    always_comb
    begin
        len_next    = len_reg;
        ovl_next    = ovl_reg;
        letter_next = letter_reg;
        chars_next  = chars_reg;
        if (start)
        begin
            chars_next[0] = b;
            len_next      = LEN_W'(1);
            ovl_next      = 1'b0;
            letter_next   = is_alpha(b);
        end
        else if (append)
        begin
            if (len_reg < LEN_W'(MAX_KEY_LEN))
            begin
                chars_next[len_reg[IDX_W-1:0]] = b;
                len_next = len_reg + LEN_W'(1);
            end
            else
                ovl_next = 1'b1;
        end
        else if (close_cur)
        begin
            len_next    = '0;
            ovl_next    = 1'b0;
            letter_next = 1'b0;
        end
    end

    // End of text closes whatever word is still open after this byte
    assign close_end = last && (mode_next == M_WORD);

    always_comb
    begin
        if (close_cur)
        begin
            w_chars = chars_reg;
            w_len   = len_reg;
            w_ok    = letter_reg && !ovl_reg;
        end
        else
        begin
            w_chars = chars_next;
            w_len   = len_next;
            w_ok    = letter_next && !ovl_next;
        end
    end

    always_comb
    begin
        logic eq;
        found     = 1'b0;
        found_sel = '0;
        for (int k = 0; k < ACTIVE; k++)
        begin
            eq = (w_len == LEN_W'(kw_len(k)));
            for (int j = 0; j < KW_TEXT_LEN; j++)
            begin
                if (j < kw_len(k))
                    eq = eq && (w_chars[j] == kw_char(k, j));
            end
            if (eq && !found)
            begin
                found     = 1'b1;
                found_sel = KW_SEL_BITS'(k);
            end
        end
    end

    assign ev.hit   = (close_cur || close_end) && w_ok && found;
    assign ev.sel   = found_sel;
    assign ev.dump  = last;
    assign ev_write = accept && (ev.hit || ev.dump);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_NORMAL;
            len_reg    <= '0;
            ovl_reg    <= 1'b0;
            letter_reg <= 1'b0;
        end
        else if (accept)
        begin
            // End of text starts the next text from scratch
            if (last)
            begin
                mode_reg   <= M_NORMAL;
                len_reg    <= '0;
                ovl_reg    <= 1'b0;
                letter_reg <= 1'b0;
            end
            else
            begin
                mode_reg   <= mode_next;
                len_reg    <= len_next;
                ovl_reg    <= ovl_next;
                letter_reg <= letter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            chars_reg <= chars_next;
    end

    `CKC_ASSERT_IMP(a_len_range, clk, rst_n, 1'b1, len_reg <= LEN_W'(MAX_KEY_LEN))
    `CKC_ASSERT_IMP(a_word_empty_outside, clk, rst_n, mode_reg != M_WORD, len_reg == '0)
    `CKC_ASSERT_NXT(a_end_resets, clk, rst_n, accept && last, mode_reg == M_NORMAL)

endmodule

[hw/rtl/ckc_queue.sv]
// ----------------------------------------------------------------------------
// ckc_queue
// Short event queue between the lexer and the counter bank.
// ----------------------------------------------------------------------------
`include "c_keyword_counter_macros.svh"

module ckc_queue
    import ckc_pkg::*;
#(
    parameter int DEPTH = EVENT_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  kw_event_t wr_data,
    input  logic      rd_en,
    output kw_event_t head,
    output q_status_t status
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kw_event_t        mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    `CKC_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `CKC_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_en, !status.full || rd_en)
    `CKC_ASSERT_IMP(a_no_underflow, clk, rst_n, rd_en, !status.empty)

endmodule

[hw/rtl/ckc_back.sv]
// ----------------------------------------------------------------------------
// ckc_back
// Counter bank: applies keyword hits and, on end of text, streams out
// every count in table order while clearing it.
// ----------------------------------------------------------------------------
`include "c_keyword_counter_macros.svh"

module ckc_back
    import ckc_pkg::*;
#(
    parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  kw_event_t   head,
    input  q_status_t   q_status,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output count_item_t count_item
);

    localparam int PTR_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] counts_reg [NUM_KEYWORDS];
    logic                  dump_reg, dump_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic                  out_valid_reg, out_valid_next;
    count_item_t           out_reg, out_next;

    logic [PTR_W-1:0]      addr;
    logic [COUNT_BITS-1:0] cur;
    logic                  out_free;
    logic                  emit;
    logic                  at_last;
    logic                  bump;

    assign out_free = !out_valid_reg || pop;
    assign q_pop    = !dump_reg && !q_status.empty;
    assign emit     = dump_reg && out_free;
    assign at_last  = (ptr_reg == PTR_W'(NUM_KEYWORDS - 1));

    // One shared read port: the dump pointer while streaming, else the hit index
    assign addr = dump_reg ? ptr_reg : PTR_W'(head.sel);
    assign cur  = counts_reg[addr];
    assign bump = q_pop && head.hit && (cur != COUNT_MAX);

    always_comb
    begin
        dump_next      = dump_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (q_pop && head.dump)
            dump_next = 1'b1;
        if (emit)
        begin
            out_next.keyword_index = KEY_INDEX_BITS'(ptr_reg);
            out_next.keyword_count = cur;
            out_next.final_entry   = at_last;
            out_valid_next         = 1'b1;
            ptr_next               = at_last ? '0 : ptr_reg + PTR_W'(1);
            if (at_last)
                dump_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dump_reg      <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_KEYWORDS; i++)
                counts_reg[i] <= '0;
        end
        else
        begin
            dump_reg      <= dump_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            // Clear each count as it leaves so the next text starts from zero
            if (bump)
                counts_reg[addr] <= cur + COUNT_BITS'(1);
            else if (emit)
                counts_reg[addr] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty      = !out_valid_reg;
    assign count_item = out_reg;

    `CKC_ASSERT_IMP(a_ptr_range, clk, rst_n, 1'b1, ptr_reg <= PTR_W'(NUM_KEYWORDS - 1))
    `CKC_ASSERT_IMP(a_ptr_idle_zero, clk, rst_n, !dump_reg, ptr_reg == '0)
    `CKC_ASSERT_NXT(a_final_ends_dump, clk, rst_n, emit && at_last, !dump_reg)
    `CKC_ASSERT_NXT(a_dump_starts, clk, rst_n, q_pop && head.dump, dump_reg)

endmodule

[hw/rtl/c_keyword_counter.sv]
// ----------------------------------------------------------------------------
// c_keyword_counter
// Counts C keywords in a byte stream of source text and dumps the counts
// at the end of each text.
//
//   Channel  Handshake       Payload        Transfer
//   input    push / full     text_item_t    push && !full
//   output   empty / pop     count_item_t   pop && !empty
//
// The lexer takes one byte every cycle while not full; a closed keyword or an
// end of text enters the event queue at the same transfer. The counter bank
// applies one event per cycle; an end of text makes it stream NUM_KEYWORDS
// results, one per cycle while pop keeps up, during which new events wait in
// the queue (EVENT_DEPTH entries) and full rises once it is filled. With the
// queue idle, an end of text passes the queue and dump flag before the first
// count is registered. Reset clears the counts at once; no clearing pass.
// ----------------------------------------------------------------------------
module c_keyword_counter
    import ckc_pkg::*;
#(
    parameter int MAX_KEY_LEN  = MAX_KEY_LEN_DEF,
    parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF,
    parameter int EVENT_DEPTH  = EVENT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  text_item_t  text_item,
    output logic        empty,
    input  logic        pop,
    output count_item_t count_item
);

    logic      accept;
    logic      ev_write;
    kw_event_t ev;
    kw_event_t head;
    q_status_t q_status;
    logic      q_pop;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    ckc_front #(
        .MAX_KEY_LEN  (MAX_KEY_LEN),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_item (text_item),
        .ev_write  (ev_write),
        .ev        (ev)
    );

    ckc_queue #(
        .DEPTH (EVENT_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_write),
        .wr_data (ev),
        .rd_en   (q_pop),
        .head    (head),
        .status  (q_status)
    );

    ckc_back #(
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .count_item (count_item)
    );

endmodule

[verif/c_keyword_counter_checker.sv]
// ----------------------------------------------------------------------------
// c_keyword_counter_checker
// Watches both queue channels of the keyword counter. Scans each text byte
// taken by the block with its own lexer, queues the twelve count results due
// at every end of text, and compares each popped result with the oldest one.
// ----------------------------------------------------------------------------
module c_keyword_counter_checker
    import ckc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  text_item_t  text_item,
    input  logic        empty,
    input  logic        pop,
    input  count_item_t count_item,
    output int          fail_count,
    output int          counts_due
);

    localparam int WORD_MAX  = 8;
    localparam int KW_COUNT  = 12;
    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        LX_NORMAL,
        LX_SLASH,
        LX_COMMENT,
        LX_COMMENT_STAR,
        LX_STRING,
        LX_STRING_ESC,
        LX_DIRECTIVE,
        LX_DIRECTIVE_ESC,
        LX_BACKSLASH,
        LX_WORD
    } lex_mode_e;

    lex_mode_e   lex_mode = LX_NORMAL;
    logic [7:0]  word_buf [WORD_MAX];
    int          word_len = 0;
    bit          word_long = 1'b0;
    bit          word_alpha = 1'b0;
    logic [15:0] kw_tally [KW_COUNT];
    count_item_t due_counts [$];
    int          fails = 0;
    int          due_size = 0;

    assign fail_count = fails;
    assign counts_due = due_size;

    function automatic string kw_name(input int k);
        string s;
        case (k)
            0:       s = "auto";
            1:       s = "break";
            2:       s = "case";
            3:       s = "char";
            4:       s = "const";
            5:       s = "continue";
            6:       s = "default";
            7:       s = "printf";
            8:       s = "unsigned";
            9:       s = "void";
            10:      s = "volatile";
            default: s = "while";
        endcase
        return s;
    endfunction

    function automatic bit letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic bit word_char(input logic [7:0] b);
        return letter(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDERLINE);
    endfunction

    function void clear_scan();
        lex_mode   = LX_NORMAL;
        word_len   = 0;
        word_long  = 1'b0;
        word_alpha = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
            kw_tally[k] = '0;
    endfunction

    function void add_char(input logic [7:0] b);
        if (word_len < WORD_MAX)
        begin
            word_buf[word_len] = b;
            word_len++;
        end
        else
            word_long = 1'b1;
    endfunction

    function void begin_word(input logic [7:0] b);
        word_len   = 0;
        word_long  = 1'b0;
        word_alpha = letter(b);
        add_char(b);
        lex_mode   = LX_WORD;
    endfunction

    function void end_word();
        string name;
        bit    same;
        bit    found;
        found = 1'b0;
        if (word_alpha && !word_long)
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                name = kw_name(k);
                if (!found && name.len() == word_len)
                begin
                    same = 1'b1;
                    for (int j = 0; j < word_len; j++)
                        if (name[j] != word_buf[j])
                            same = 1'b0;
                    if (same)
                    begin
                        found = 1'b1;
                        if (kw_tally[k] != TALLY_MAX)
                            kw_tally[k] = kw_tally[k] + 16'd1;
                    end
                end
            end
        end
        word_len   = 0;
        word_long  = 1'b0;
        word_alpha = 1'b0;
        lex_mode   = LX_NORMAL;
    endfunction

    function void token_begin(input logic [7:0] b);
        if (b == CH_SLASH)
            lex_mode = LX_SLASH;
        else if (b == CH_QUOTE)
            lex_mode = LX_STRING;
        else if (b == CH_HASH)
            lex_mode = LX_DIRECTIVE;
        else if (b == CH_BACKSLASH)
            lex_mode = LX_BACKSLASH;
        else if (word_char(b))
            begin_word(b);
        else
            lex_mode = LX_NORMAL;
    endfunction

    function void scan_byte(input logic [7:0] b, input logic last);
        count_item_t entry;
        case (lex_mode)
            LX_SLASH:
                if (b == CH_STAR)
                    lex_mode = LX_COMMENT;
                else
                    token_begin(b);
            LX_COMMENT:
                if (b == CH_STAR)
                    lex_mode = LX_COMMENT_STAR;
            LX_COMMENT_STAR:
                if (b == CH_SLASH)
                    lex_mode = LX_NORMAL;
                else if (b != CH_STAR)
                    lex_mode = LX_COMMENT;
            LX_STRING:
                if (b == CH_BACKSLASH)
                    lex_mode = LX_STRING_ESC;
                else if (b == CH_QUOTE)
                    lex_mode = LX_NORMAL;
            LX_STRING_ESC:
                lex_mode = LX_STRING;
            LX_DIRECTIVE:
                if (b == CH_BACKSLASH)
                    lex_mode = LX_DIRECTIVE_ESC;
                else if (b == CH_NEWLINE)
                    lex_mode = LX_NORMAL;
            LX_DIRECTIVE_ESC:
                lex_mode = LX_DIRECTIVE;
            LX_BACKSLASH:
                if (word_char(b))
                    begin_word(b);
                else
                    lex_mode = LX_NORMAL;
            LX_WORD:
                if (word_char(b))
                    add_char(b);
                else
                begin
                    end_word();
                    token_begin(b);
                end
            default:
                token_begin(b);
        endcase

        if (last)
        begin
            // close the pending word, queue the dump and start a fresh text
            if (lex_mode == LX_WORD)
                end_word();
            for (int k = 0; k < KW_COUNT; k++)
            begin
                entry.keyword_index = k[KEY_INDEX_BITS-1:0];
                entry.keyword_count = kw_tally[k];
                entry.final_entry   = (k == KW_COUNT - 1);
                due_counts.push_back(entry);
            end
            clear_scan();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        count_item_t want;
        if (!rst_n)
        begin
            clear_scan();
            due_counts.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_counts.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected result: idx %0d count %0d last %0b",
                                 count_item.keyword_index, count_item.keyword_count,
                                 count_item.final_entry);
                    fails++;
                end
                else
                begin
                    want = due_counts.pop_front();
                    if (count_item.keyword_index !== want.keyword_index ||
                        count_item.keyword_count !== want.keyword_count ||
                        count_item.final_entry   !== want.final_entry)
                    begin
                        if (fails < 10)
                            $display("count mismatch: want %0d/%0d/%0b, got %0d/%0d/%0b",
                                     want.keyword_index, want.keyword_count,
                                     want.final_entry, count_item.keyword_index,
                                     count_item.keyword_count, count_item.final_entry);
                        fails++;
                    end
                end
            end
            if (push && !full)
                scan_byte(text_item.text_byte, text_item.end_of_text);
        end
        due_size = due_counts.size();
    end

endmodule

[verif/c_keyword_counter_tb.sv]
// ----------------------------------------------------------------------------
// c_keyword_counter_tb
// Feeds the keyword counter with C-like text: a few hand-made texts, then
// random texts of keywords, words, comments, strings, directives, escapes and
// raw bytes under three idling mixes and a long receiver stall. The checker
// beside the block predicts and compares every count.
// ----------------------------------------------------------------------------
module c_keyword_counter_tb;
    import ckc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    text_item_t  text_item = '0;
    logic        full;
    logic        empty;
    count_item_t count_item;
    int          fail_count;
    int          counts_due;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_req = 0;
    int          sent_items = 0;
    logic [7:0]  text_q [$];

    c_keyword_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .text_item  (text_item),
        .empty      (empty),
        .pop        (pop),
        .count_item (count_item)
    );

    c_keyword_counter_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .text_item  (text_item),
        .empty      (empty),
        .pop        (pop),
        .count_item (count_item),
        .fail_count (fail_count),
        .counts_due (counts_due)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #24000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random pop, with a long hold-off whenever one is requested
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < hold_req)
            begin
                holds_done++;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic string kw_text(input int k);
        string s;
        case (k)
            0:       s = "auto";
            1:       s = "break";
            2:       s = "case";
            3:       s = "char";
            4:       s = "const";
            5:       s = "continue";
            6:       s = "default";
            7:       s = "printf";
            8:       s = "unsigned";
            9:       s = "void";
            10:      s = "volatile";
            default: s = "while";
        endcase
        return s;
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'h61 + 8'(r);
        else if (r < 52)
            return 8'h41 + 8'(r - 26);
        else if (r < 62)
            return 8'h30 + 8'(r - 52);
        return CH_UNDERLINE;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        text_item <= '{text_byte: b, end_of_text: last};
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_item(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_keyword();
        string s;
        s = kw_text($urandom_range(0, 11));
        case ($urandom_range(0, 9))
            0:       s[0] = s[0] - 8'h20;             // capitalised: no match
            1:       s = {s, "x"};
            2:       s = {"_", s};
            3:       s = {s, "9"};
            default: ;
        endcase
        add_str(s);
    endtask

    task automatic add_word();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
        repeat (n)
            text_q.push_back(rand_word_char());
    endtask

    task automatic add_inner();
        case ($urandom_range(0, 5))
            0:       add_keyword();
            1:       add_word();
            2:       text_q.push_back(8'h20);
            3:       text_q.push_back(8'($urandom_range(0, 255)));
            4:       text_q.push_back(CH_STAR);
            default: text_q.push_back(CH_SLASH);
        endcase
    endtask

    task automatic add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            add_keyword();
        else if (r < 50)
            add_word();
        else if (r < 62)
        begin
            case ($urandom_range(0, 6))
                0:       text_q.push_back(8'h20);
                1:       text_q.push_back(CH_NEWLINE);
                2:       text_q.push_back(8'h09);
                3:       text_q.push_back(8'h3B);
                4:       text_q.push_back(8'h28);
                5:       text_q.push_back(CH_STAR);
                default: text_q.push_back(CH_SLASH);
            endcase
        end
        else if (r < 70)
        begin
            add_str("/*");
            repeat ($urandom_range(0, 6))
                add_inner();
            add_str($urandom_range(0, 1) ? "*/" : "**/");
        end
        else if (r < 78)
        begin
            text_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 3))
                    0:       add_str("\\\"");
                    1:       add_str("\\\\");
                    default: add_inner();
                endcase
            end
            text_q.push_back(CH_QUOTE);
        end
        else if (r < 86)
        begin
            text_q.push_back(CH_HASH);
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(0, 3) == 0)
                    add_str("\\\n");
                else
                    add_inner();
            end
            text_q.push_back(CH_NEWLINE);
        end
        else if (r < 93)
        begin
            text_q.push_back(CH_BACKSLASH);
            if ($urandom_range(0, 1))
                add_keyword();
            else
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_text();
        repeat ($urandom_range(3, 24))
            add_token();
        // leave some texts open inside a construct
        if ($urandom_range(0, 5) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       add_str("/*ab");
                1:       add_str("\"case");
                2:       add_str("#char");
                3:       add_str("\\");
                default: add_str("/");
            endcase
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int n_items);
        int start;
        send_idle = s_idle;
        recv_idle = r_idle;
        start     = sent_items;
        while (sent_items - start < n_items)
        begin
            build_text();
            send_text();
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle = 16;
        recv_idle = 48;

        // comment with a star run, top byte, escaped word start, word open at end
        add_str("char/*a**/");
        text_q.push_back(8'hFF);
        add_str("\\case");
        send_text();
        // escaped quote in a string, continued directive, escaped slash, zero byte
        add_str("\"\\\"\"#\\\nvoid\n\\/");
        text_q.push_back(8'h00);
        send_text();
        // lone slash, then end of text inside an open comment
        add_str("a/b/*");
        send_text();

        // hold the receiver off while dumps pile up behind it
        hold_req++;
        send_idle = 0;
        repeat (4)
        begin
            add_str("auto case while ");
            send_text();
        end

        run_phase(16, 48, 80);
        run_phase(48, 16, 80);
        run_phase(0, 0, 80);

        push <= 1'b0;
        wait (counts_due == 0);
        repeat (30)
            @(posedge clk);
        if (fail_count == 0 && counts_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ckc_pkg.sv
hw/rtl/ckc_front.sv
hw/rtl/ckc_queue.sv
hw/rtl/ckc_back.sv
hw/rtl/c_keyword_counter.sv
verif/c_keyword_counter_checker.sv
verif/c_keyword_counter_tb.sv
